// ----- sv/spq_pkg.sv -----
// spq_pkg: shared types and codes of the sorted priority queue
// payload structs, stored entry, controller commands and status, state enum
// no dependencies
package spq_pkg;

  // operation codes of an input item
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // result status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic               opcode;
    logic [15:0]        priority_req;
    logic signed [31:0] payload;
  } spq_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [15:0]        out_priority;
    logic signed [31:0] out_payload;
    logic [4:0]         fill_level;
  } spq_out_t;

  // one stored entry
  typedef struct packed {
    logic [15:0]        prio;
    logic signed [31:0] data;
  } spq_entry_t;

  // controller to datapath
  typedef struct packed {
    logic       latch;       // take the input item, k from fill count
    logic       rd_head;     // read the head slot
    logic       rd_prev;     // read the slot before position k
    logic       shift;       // move the entry just read back to position k
    logic       put_new;     // write the new entry at position k
    logic       pop;         // advance head, drop one entry, keep its fields
    logic       set_status;  // record a reject status
    logic [1:0] status;
    logic       load_out;    // move the result into the output register
  } spq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_remove;
    logic full;
    logic empty;
    logic k_zero;
    logic greater;   // entry just read has a higher priority value than the request
    logic out_free;
  } spq_stat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_CMP,
    S_POP,
    S_FIN
  } spq_state_t;

endpackage

// ----- sv/spq_ctrl.sv -----
// spq_ctrl: sequencer of the sorted priority queue
// walks an insert from the tail towards the head, reading one entry in S_DECIDE and shifting it in S_CMP
// depends on spq_pkg
module spq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  spq_pkg::spq_stat_t stat,
  output spq_pkg::spq_cmd_t  cmd
);
  import spq_pkg::*;

  spq_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (stat.is_remove) begin
          state_nxt = stat.empty ? S_FIN : S_POP;
        end else if (stat.full || stat.k_zero) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        state_nxt = stat.greater ? S_DECIDE : S_FIN;
      end
      S_POP: begin
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // command outputs; no transfer is taken while reset is held
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready  = rst_n;
        cmd.latch = in_valid && rst_n;
      end
      S_DECIDE: begin
        if (stat.is_remove) begin
          if (stat.empty) begin
            cmd.set_status = 1'b1;
            cmd.status     = ST_EMPTY;
          end else begin
            cmd.rd_head = 1'b1;
          end
        end else if (stat.full) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_FULL;
        end else if (stat.k_zero) begin
          cmd.put_new = 1'b1;
        end else begin
          cmd.rd_prev = 1'b1;
        end
      end
      S_CMP: begin
        if (stat.greater) begin
          cmd.shift = 1'b1;
        end else begin
          cmd.put_new = 1'b1;
        end
      end
      S_POP: begin
        cmd.pop = 1'b1;
      end
      S_FIN: begin
        cmd.load_out = stat.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ----- sv/spq_dpath.sv -----
// spq_dpath: circular entry store, head and fill count, result and output registers
// driven by spq_ctrl through command and status structs
// depends on spq_pkg
module spq_dpath #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  spq_pkg::spq_in_t   in_data,
  input  spq_pkg::spq_cmd_t  cmd,
  output spq_pkg::spq_stat_t stat,
  output logic               out_valid,
  input  logic               out_ready,
  output spq_pkg::spq_out_t  out_data
);
  import spq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  spq_entry_t mem [DEPTH];
  spq_entry_t rd_data_r;

  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] k_r;
  spq_in_t       req_r;

  logic [1:0]         res_status_r;
  logic [15:0]        res_prio_r;
  logic signed [31:0] res_data_r;

  logic     out_valid_r;
  spq_out_t out_data_r;

  logic [CW:0]   sum;
  logic [CW:0]   sum_w;
  logic [AW-1:0] slot_k;
  logic [AW-1:0] slot_km1;
  logic [AW-1:0] rd_addr;
  spq_entry_t    wr_entry;

  // store slot of position k and of the one before it, modulo depth
  always_comb begin
    sum      = (CW+1)'(head_r) + (CW+1)'(k_r);
    sum_w    = (sum >= (CW+1)'(DEPTH)) ? sum - (CW+1)'(DEPTH) : sum;
    slot_k   = sum_w[AW-1:0];
    slot_km1 = (slot_k == '0) ? AW'(DEPTH - 1) : slot_k - 1'b1;
    rd_addr  = cmd.rd_head ? head_r : slot_km1;
    wr_entry = cmd.shift ? rd_data_r : spq_entry_t'{req_r.priority_req, req_r.payload};
  end

  // entry store, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.shift || cmd.put_new) begin
      mem[slot_k] <= wr_entry;
    end
    if (cmd.rd_head || cmd.rd_prev) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // head and fill count
  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    if (cmd.pop) begin
      head_nxt  = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + 1'b1;
      count_nxt = count_r - 1'b1;
    end else if (cmd.put_new) begin
      count_nxt = count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  // request, walk position and result fields
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_r        <= in_data;
      k_r          <= count_r;
      res_status_r <= ST_DONE;
      res_prio_r   <= '0;
      res_data_r   <= '0;
    end else begin
      if (cmd.shift) k_r <= k_r - 1'b1;
      if (cmd.set_status) res_status_r <= cmd.status;
      if (cmd.pop) begin
        res_prio_r <= rd_data_r.prio;
        res_data_r <= rd_data_r.data;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r.status       <= res_status_r;
      out_data_r.out_priority <= res_prio_r;
      out_data_r.out_payload  <= res_data_r;
      out_data_r.fill_level   <= 5'(count_r);
    end
  end

  // status towards the controller
  always_comb begin
    stat.is_remove = (req_r.opcode == OP_REMOVE);
    stat.full      = (count_r == CW'(DEPTH));
    stat.empty     = (count_r == '0);
    stat.k_zero    = (k_r == '0);
    stat.greater   = (rd_data_r.prio > req_r.priority_req);
    stat.out_free  = !out_valid_r || out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- sv/sorted_priority_queue.sv -----
// sorted_priority_queue: bounded priority queue kept sorted in a circular store
// top level joining spq_ctrl and spq_dpath
// depends on spq_pkg, spq_ctrl, spq_dpath
//
//   channel  ports                          moves
//   input    in_valid, in_ready, in_data    opcode, priority_req, payload
//   output   out_valid, out_ready, out_data status, out_priority, out_payload, fill_level
//
// one item at a time; a remove passes S_DECIDE, which reads the head, and S_POP; a rejected item
// goes from S_DECIDE straight to S_FIN; an insert reads each entry of higher priority value in
// S_DECIDE and moves it one place back in S_CMP, through the single write port of the store,
// then writes the new entry in S_CMP, or in S_DECIDE when every held entry was moved
// synchronous active-low reset empties the queue; stored entries are not cleared
// a stalled output holds the result in the output register; the next item is then
// taken and worked on, and waits only to hand over its own result
module sorted_priority_queue #(
  parameter int DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  spq_pkg::spq_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output spq_pkg::spq_out_t out_data
);
  import spq_pkg::*;

  spq_cmd_t  cmd;
  spq_stat_t stat;

  // sequencer
  spq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // store and registers
  spq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
